// File: rtl/rgbh_pkg.sv
// ----------------------------------------------------------------------------
// rgbh_pkg: shared types and constants for the RGB to HSV converter
// Field widths, divider chain length and the stage record passed cell to cell.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbh_pkg;

  // pixel and result field widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 9;

  // hue numerator reaches 360*255, saturation numerator 255*255
  localparam int unsigned HueRemW = 17;
  localparam int unsigned SatRemW = 16;

  // one quotient bit per cell; hue needs nine bits, saturation eight
  localparam int unsigned NumCells = HueW;

  // hue offsets and scale factors
  localparam int unsigned HueStep  = 60;
  localparam int unsigned HueGreen = 120;
  localparam int unsigned HueBlue  = 240;
  localparam int unsigned HueFull  = 360;
  localparam int unsigned SatScale = 255;

  // partial division state moving down the chain
  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;
    logic [ChanW-1:0]   hue_div;
    logic [HueW-1:0]    hue_q;
    logic [SatRemW-1:0] sat_rem;
    logic [ChanW-1:0]   sat_div;
    logic [HueW-1:0]    sat_q;
    logic [ChanW-1:0]   bright;
  } stage_t;

endpackage

`default_nettype wire

// File: rtl/rgbh_in_if.sv
// ----------------------------------------------------------------------------
// rgbh_in_if: pixel input channel
// Valid/ready handshake carrying one RGB pixel per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbh_in_if;
  logic                      valid;
  logic                      ready;
  logic [rgbh_pkg::ChanW-1:0] red_in;
  logic [rgbh_pkg::ChanW-1:0] green_in;
  logic [rgbh_pkg::ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rgbh_out_if.sv
// ----------------------------------------------------------------------------
// rgbh_out_if: HSV result channel
// Valid/ready handshake carrying one HSV result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbh_out_if;
  logic                      valid;
  logic                      ready;
  logic [rgbh_pkg::HueW-1:0]  hue_deg;
  logic [rgbh_pkg::ChanW-1:0] saturation;
  logic [rgbh_pkg::ChanW-1:0] brightness;

  modport source (output valid, output hue_deg, output saturation,
                  output brightness, input ready);
  modport sink   (input valid, input hue_deg, input saturation,
                  input brightness, output ready);
endinterface

`default_nettype wire

// File: rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv: 8-bit RGB to HSV pixel converter
// Front stage plus a chain of nine division cells, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns hue in whole degrees (0-359, floor),
// saturation floor(255*(max-min)/max) and value = max channel. Gray and black
// pixels give hue and saturation of zero; red wins ties for the largest
// channel, then green. Each result is registered in the front stage and then
// in each of nine cells in turn, every cell producing one quotient bit of
// both divisions. A new pixel can enter every cycle. When out_px.ready is low
// while a result waits, the whole chain holds and in_px.ready drops until the
// result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv (
  input  wire logic clk,
  input  wire logic rst_n,
  rgbh_in_if.sink   in_px,
  rgbh_out_if.source out_px
);

  localparam int unsigned N  = rgbh_pkg::NumCells;
  localparam int unsigned CW = rgbh_pkg::ChanW;

  logic             adv;
  logic             vld [N+1];
  rgbh_pkg::stage_t stg [N+1];

  // the chain moves unless a finished result is stuck at the output
  assign adv         = !vld[N] || out_px.ready;
  assign in_px.ready = adv;

  rgbh_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_px.valid),
    .red       (in_px.red_in),
    .green     (in_px.green_in),
    .blue      (in_px.blue_in),
    .out_valid (vld[0]),
    .out_stage (stg[0])
  );

  // quotient bits most significant first
  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbh_cell #(
      .SHIFT (N - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (vld[i]),
      .in_stage  (stg[i]),
      .out_valid (vld[i+1]),
      .out_stage (stg[i+1])
    );
  end

  // last cell register is the output register
  assign out_px.valid      = vld[N];
  assign out_px.hue_deg    = stg[N].hue_q;
  assign out_px.saturation = stg[N].sat_q[CW-1:0];
  assign out_px.brightness = stg[N].bright;

endmodule

`default_nettype wire

// File: rtl/rgbh_prep.sv
// ----------------------------------------------------------------------------
// rgbh_prep: front stage of the converter
// Finds max/min, builds hue and saturation numerators and divisors, registers
// them as the first entry of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbh_prep (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic [rgbh_pkg::ChanW-1:0] red,
  input  wire logic [rgbh_pkg::ChanW-1:0] green,
  input  wire logic [rgbh_pkg::ChanW-1:0] blue,
  output logic                            out_valid,
  output rgbh_pkg::stage_t                out_stage
);

  localparam int unsigned RW = rgbh_pkg::HueRemW;
  localparam int unsigned SW = rgbh_pkg::SatRemW;
  localparam int unsigned CW = rgbh_pkg::ChanW;

  logic [CW-1:0] mx, mn, delta;
  logic [RW-1:0] d_ext, diff_gb, diff_br, diff_rg, diff_bg, diff_rb, diff_gr;
  logic [RW-1:0] num;
  logic          valid_r;
  rgbh_pkg::stage_t stage_r, stage_nxt;

  // largest and smallest channel
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    delta = mx - mn;
  end

  // channel differences, widened for the numerator
  assign d_ext   = RW'(delta);
  assign diff_gb = RW'(green) - RW'(blue);
  assign diff_bg = RW'(blue)  - RW'(green);
  assign diff_br = RW'(blue)  - RW'(red);
  assign diff_rb = RW'(red)   - RW'(blue);
  assign diff_rg = RW'(red)   - RW'(green);
  assign diff_gr = RW'(green) - RW'(red);

  // hue numerator; red wins ties, then green
  always_comb begin
    if (mx == red) begin
      if (green >= blue) num = RW'(rgbh_pkg::HueStep) * diff_gb;
      else num = RW'(rgbh_pkg::HueFull) * d_ext - RW'(rgbh_pkg::HueStep) * diff_bg;
    end else if (mx == green) begin
      if (blue >= red) num = RW'(rgbh_pkg::HueGreen) * d_ext
                             + RW'(rgbh_pkg::HueStep) * diff_br;
      else num = RW'(rgbh_pkg::HueGreen) * d_ext - RW'(rgbh_pkg::HueStep) * diff_rb;
    end else begin
      if (red >= green) num = RW'(rgbh_pkg::HueBlue) * d_ext
                              + RW'(rgbh_pkg::HueStep) * diff_rg;
      else num = RW'(rgbh_pkg::HueBlue) * d_ext - RW'(rgbh_pkg::HueStep) * diff_gr;
    end
  end

  // gray or black: divide zero by one so both quotients come out zero
  always_comb begin
    stage_nxt.bright = mx;
    stage_nxt.hue_q  = '0;
    stage_nxt.sat_q  = '0;
    if (delta == '0) begin
      stage_nxt.hue_rem = '0;
      stage_nxt.hue_div = CW'(1);
      stage_nxt.sat_rem = '0;
      stage_nxt.sat_div = CW'(1);
    end else begin
      stage_nxt.hue_rem = num;
      stage_nxt.hue_div = delta;
      stage_nxt.sat_rem = SW'(rgbh_pkg::SatScale) * SW'(delta);
      stage_nxt.sat_div = mx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire

// File: rtl/rgbh_cell.sv
// ----------------------------------------------------------------------------
// rgbh_cell: one restoring-division step for hue and saturation
// Compares each partial remainder with its divisor shifted by SHIFT, subtracts
// when it fits and shifts the quotient bit in, then registers the record.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbh_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire rgbh_pkg::stage_t in_stage,
  output logic                  out_valid,
  output rgbh_pkg::stage_t      out_stage
);

  localparam int unsigned RW = rgbh_pkg::HueRemW;
  localparam int unsigned SW = rgbh_pkg::SatRemW;
  localparam int unsigned QW = rgbh_pkg::HueW;

  logic [RW-1:0] hue_cmp;
  logic [SW-1:0] sat_cmp;
  logic          hue_ge, sat_ge;
  logic          valid_r;
  rgbh_pkg::stage_t stage_r, stage_nxt;

  // shifted divisors for this bit position
  assign hue_cmp = RW'(in_stage.hue_div) << SHIFT;
  assign sat_cmp = SW'(in_stage.sat_div) << SHIFT;
  assign hue_ge  = in_stage.hue_rem >= hue_cmp;
  assign sat_ge  = in_stage.sat_rem >= sat_cmp;

  // conditional subtract, quotient bit shifted in from the right
  always_comb begin
    stage_nxt         = in_stage;
    stage_nxt.hue_rem = hue_ge ? in_stage.hue_rem - hue_cmp : in_stage.hue_rem;
    stage_nxt.sat_rem = sat_ge ? in_stage.sat_rem - sat_cmp : in_stage.sat_rem;
    stage_nxt.hue_q   = {in_stage.hue_q[QW-2:0], hue_ge};
    stage_nxt.sat_q   = {in_stage.sat_q[QW-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;

endmodule

`default_nettype wire
